// ===== sv/h264idr_pkg.sv =====
// Shared types, codes and the Exp-Golomb bit step for the H.264 IDR detector.
// Used by every module of the detector; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package h264idr_pkg;

    // Stream widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 8;

    // NAL unit types of interest
    localparam logic [4:0] NAL_KIND_MASK       = 5'h1f;
    localparam logic [4:0] NAL_KIND_SLICE      = 5'd1;
    localparam logic [4:0] NAL_KIND_IDR        = 5'd5;
    localparam logic [4:0] NAL_KIND_SPS        = 5'd7;
    localparam logic [4:0] NAL_KIND_SUBSET_SPS = 5'd15;

    // Start code framing
    localparam logic [7:0] START_CODE_ONE = 8'h01;
    localparam logic [1:0] ZERO_RUN_MAX   = 2'd2;
    localparam logic [1:0] LOOKAHEAD      = 2'd3;

    // Exp-Golomb limits and the intra slice types
    localparam logic [4:0]  MAX_LEAD_ZEROS = 5'd15;
    localparam logic [15:0] SLICE_KIND_I     = 16'd2;
    localparam logic [15:0] SLICE_KIND_I_ALL = 16'd7;

    typedef enum logic [1:0] {
        VERDICT_UNDECIDED = 2'd0,
        VERDICT_IDR       = 2'd1,
        VERDICT_NOT_IDR   = 2'd2
    } verdict_t;

    typedef enum logic [1:0] {
        PHASE_IDLE   = 2'd0,
        PHASE_FIRST  = 2'd1,
        PHASE_SECOND = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        STATUS_IDR_SPS = 2'd0,
        STATUS_NO_SPS  = 2'd1,
        STATUS_NO_IDR  = 2'd2
    } status_t;

    // Decoder state for the slice header codes
    typedef struct packed {
        phase_t      phase;
        logic [4:0]  lead;
        logic [15:0] code;
        verdict_t    verdict;
    } golomb_t;

    // Event from the start code scanner to the slice decoder
    typedef struct packed {
        logic       start_found;
        logic [4:0] unit_kind;
    } scan_evt_t;

    localparam golomb_t GOLOMB_FRESH = '{
        phase:   PHASE_FIRST,
        lead:    5'd0,
        code:    16'd0,
        verdict: VERDICT_UNDECIDED
    };

    // One bit into the ue(v) decoder: count zeros, then shift in the info bits.
    function automatic golomb_t golomb_bit(input golomb_t s, input logic bit_in);
        golomb_t     r;
        logic [15:0] val;
        r   = s;
        val = 16'd0;
        if (s.phase != PHASE_IDLE)
        begin
            if (s.code == 16'd0)
            begin
                if (!bit_in)
                begin
                    if (s.lead >= MAX_LEAD_ZEROS)
                    begin
                        r.phase   = PHASE_IDLE;
                        r.lead    = 5'd0;
                        r.verdict = VERDICT_NOT_IDR;
                    end
                    else
                    begin
                        r.lead = s.lead + 5'd1;
                    end
                end
                else
                begin
                    r.code = 16'd1;
                end
            end
            else
            begin
                r.code = {s.code[14:0], bit_in};
                r.lead = s.lead - 5'd1;
            end
            // A code is complete once all its info bits are in
            if (r.phase != PHASE_IDLE && r.code != 16'd0 && r.lead == 5'd0)
            begin
                val    = r.code - 16'd1;
                r.code = 16'd0;
                if (s.phase == PHASE_FIRST)
                begin
                    r.phase = PHASE_SECOND;
                end
                else
                begin
                    r.phase   = PHASE_IDLE;
                    r.verdict = (val == SLICE_KIND_I || val == SLICE_KIND_I_ALL) ?
                                VERDICT_IDR : VERDICT_NOT_IDR;
                end
            end
        end
        return r;
    endfunction

    // A whole byte, most significant bit first
    function automatic golomb_t golomb_byte(input golomb_t s, input logic [7:0] b);
        golomb_t r;
        r = s;
        for (int k = 7; k >= 0; k--)
        begin
            r = golomb_bit(r, b[k]);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/h264idr_scan.sv =====
// Start code scanner: byte window, zero run, previous NAL type and SPS flag.
// Depends on h264idr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module h264idr_scan (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  accept,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  last_byte,
    output h264idr_pkg::scan_evt_t     evt,
    output logic                       sps_final
);

    logic [7:0] win_reg [3];
    logic [7:0] win_next [3];
    logic [1:0] seen_reg, seen_next;
    logic [1:0] zrun_reg, zrun_next;
    logic [4:0] prev_reg, prev_next;
    logic       sps_reg, sps_next;

    // Scan the byte three places back and look for 00 00 01
    always_comb
    begin
        seen_next       = seen_reg;
        zrun_next       = zrun_reg;
        prev_next       = prev_reg;
        sps_next        = sps_reg;
        evt.start_found = 1'b0;
        evt.unit_kind   = win_reg[1][4:0] & h264idr_pkg::NAL_KIND_MASK;
        if (seen_reg == h264idr_pkg::LOOKAHEAD)
        begin
            if (win_reg[0] == 8'd0)
            begin
                if (zrun_reg < h264idr_pkg::ZERO_RUN_MAX)
                begin
                    zrun_next = zrun_reg + 2'd1;
                end
            end
            else
            begin
                if (zrun_reg >= h264idr_pkg::ZERO_RUN_MAX &&
                    win_reg[0] == h264idr_pkg::START_CODE_ONE)
                begin
                    evt.start_found = 1'b1;
                    if (prev_reg == h264idr_pkg::NAL_KIND_SPS ||
                        prev_reg == h264idr_pkg::NAL_KIND_SUBSET_SPS)
                    begin
                        sps_next = 1'b1;
                    end
                    prev_next = evt.unit_kind;
                end
                zrun_next = 2'd0;
            end
        end
        else
        begin
            seen_next = seen_reg + 2'd1;
        end
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = data_byte;
        sps_final   = sps_next;
    end

    // State update; the last byte of a buffer returns everything to reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= '{default: 8'd0};
            seen_reg <= 2'd0;
            zrun_reg <= 2'd0;
            prev_reg <= 5'd0;
            sps_reg  <= 1'b0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                win_reg  <= '{default: 8'd0};
                seen_reg <= 2'd0;
                zrun_reg <= 2'd0;
                prev_reg <= 5'd0;
                sps_reg  <= 1'b0;
            end
            else
            begin
                win_reg  <= win_next;
                seen_reg <= seen_next;
                zrun_reg <= zrun_next;
                prev_reg <= prev_next;
                sps_reg  <= sps_next;
            end
        end
    end

`ifndef SYNTHESIS
    // The zero run saturates at two
    a_zrun_range: assert property (@(posedge clk) disable iff (!rst_n)
        zrun_reg <= h264idr_pkg::ZERO_RUN_MAX)
        else $error("zero run out of range");

    // No byte is scanned before the window has filled
    a_zrun_needs_window: assert property (@(posedge clk) disable iff (!rst_n)
        (seen_reg != h264idr_pkg::LOOKAHEAD) |-> (zrun_reg == 2'd0 && !sps_reg))
        else $error("scan state changed before the window filled");
`endif

endmodule

`default_nettype wire

// ===== sv/h264idr_golomb.sv =====
// Slice decision: IDR NAL kind or the slice kind from two ue(v) header codes.
// Depends on h264idr_pkg (golomb_byte function and state types).
`timescale 1ns / 1ps
`default_nettype none

module h264idr_golomb (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   accept,
    input  wire logic [7:0]             data_byte,
    input  wire logic                   last_byte,
    input  wire h264idr_pkg::scan_evt_t evt,
    output h264idr_pkg::verdict_t       verdict_final
);

    h264idr_pkg::golomb_t st_reg, st_next;
    h264idr_pkg::golomb_t spec_reg;
    h264idr_pkg::golomb_t fed;
    logic                 start_ok;

    // The first header byte was decoded from a fresh state as it arrived,
    // so at the start code only the current byte still has to go through.
    always_comb
    begin
        fed      = h264idr_pkg::golomb_byte(st_reg, data_byte);
        start_ok = evt.start_found &&
                   st_reg.verdict == h264idr_pkg::VERDICT_UNDECIDED &&
                   st_reg.phase == h264idr_pkg::PHASE_IDLE;
        st_next  = fed;
        if (start_ok)
        begin
            if (evt.unit_kind == h264idr_pkg::NAL_KIND_IDR)
            begin
                st_next.verdict = h264idr_pkg::VERDICT_IDR;
            end
            else if (evt.unit_kind == h264idr_pkg::NAL_KIND_SLICE)
            begin
                st_next = h264idr_pkg::golomb_byte(spec_reg, data_byte);
            end
        end
        // A code cut off by the end of the buffer counts as not IDR
        if (st_next.phase != h264idr_pkg::PHASE_IDLE)
        begin
            verdict_final = h264idr_pkg::VERDICT_NOT_IDR;
        end
        else
        begin
            verdict_final = st_next.verdict;
        end
    end

    // Decoder state, cleared after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.phase   <= h264idr_pkg::PHASE_IDLE;
            st_reg.lead    <= 5'd0;
            st_reg.code    <= 16'd0;
            st_reg.verdict <= h264idr_pkg::VERDICT_UNDECIDED;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                st_reg.phase   <= h264idr_pkg::PHASE_IDLE;
                st_reg.lead    <= 5'd0;
                st_reg.code    <= 16'd0;
                st_reg.verdict <= h264idr_pkg::VERDICT_UNDECIDED;
            end
            else
            begin
                st_reg <= st_next;
            end
        end
    end

    // Speculative decode of each byte from a fresh first-code state
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            spec_reg <= h264idr_pkg::golomb_byte(h264idr_pkg::GOLOMB_FRESH, data_byte);
        end
    end

`ifndef SYNTHESIS
    // An idle decoder holds no partial code
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.phase == h264idr_pkg::PHASE_IDLE) |-> (st_reg.lead == 5'd0 &&
                                                       st_reg.code == 16'd0))
        else $error("idle decoder holds a partial code");

    // A running decoder never has a verdict yet
    a_running_undecided: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.phase != h264idr_pkg::PHASE_IDLE) |->
        (st_reg.verdict == h264idr_pkg::VERDICT_UNDECIDED &&
         st_reg.lead <= h264idr_pkg::MAX_LEAD_ZEROS))
        else $error("decoder running with a verdict or too many zeros");
`endif

endmodule

`default_nettype wire

// ===== sv/h264idr_outbuf.sv =====
// Result register with a skid stage, so input bytes keep flowing while a
// status waits on the output. Depends on h264idr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module h264idr_outbuf (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire h264idr_pkg::status_t  push_status,
    output logic                       space,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [h264idr_pkg::M_TDATA_W-1:0] m_tdata
);

    logic                  out_valid_reg;
    h264idr_pkg::status_t  out_status_reg;
    logic                  skid_valid_reg;
    h264idr_pkg::status_t  skid_status_reg;
    logic                  pop;

    assign pop      = out_valid_reg && m_tready;
    assign space    = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(h264idr_pkg::M_TDATA_W - 2){1'b0}}, out_status_reg};

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg  <= skid_valid_reg || push;
                skid_valid_reg <= skid_valid_reg && push;
            end
            else if (push)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= out_valid_reg;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_status_reg <= skid_status_reg;
                if (push)
                begin
                    skid_status_reg <= push_status;
                end
            end
            else if (push)
            begin
                out_status_reg <= push_status;
            end
        end
        else if (push)
        begin
            if (out_valid_reg)
            begin
                skid_status_reg <= push_status;
            end
            else
            begin
                out_status_reg <= push_status;
            end
        end
    end

`ifndef SYNTHESIS
    // The skid stage fills only behind a waiting result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full with output empty");
`endif

endmodule

`default_nettype wire

// ===== sv/h264_idr_access_unit_detector.sv =====
// The status is registered in the output buffer and shows on m_tvalid once any earlier result is read.
// Throughput: one byte per cycle while s_tready is high; every byte is handled in the cycle it is taken.
// s_tready falls only while two status results wait unread in the output buffer.
// Reset (rst_n low, asynchronous) clears the scan and decoder state, all but spec_reg; no clearing pass.
// The last byte of each buffer also returns that state to reset.
// Top level of the IDR detector; depends on h264idr_pkg and the h264idr_* modules.
`timescale 1ns / 1ps
`default_nettype none

module h264_idr_access_unit_detector (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    input  wire logic [h264idr_pkg::S_TDATA_W-1:0]      s_tdata,  // [7:0] data_byte
    input  wire logic                                   s_tlast,  // last_byte
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic [h264idr_pkg::M_TDATA_W-1:0]           m_tdata   // [1:0] status, rest zero
);

    logic                   accept;
    logic                   space;
    logic                   sps_final;
    h264idr_pkg::scan_evt_t evt;
    h264idr_pkg::verdict_t  verdict_final;
    h264idr_pkg::status_t   status;

    assign s_tready = space;
    assign accept   = s_tvalid && space;

    h264idr_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .evt       (evt),
        .sps_final (sps_final)
    );

    h264idr_golomb u_golomb (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (s_tdata),
        .last_byte     (s_tlast),
        .evt           (evt),
        .verdict_final (verdict_final)
    );

    // Status priority: a missing SPS outranks the slice verdict
    always_comb
    begin
        if (!sps_final)
        begin
            status = h264idr_pkg::STATUS_NO_SPS;
        end
        else if (verdict_final != h264idr_pkg::VERDICT_IDR)
        begin
            status = h264idr_pkg::STATUS_NO_IDR;
        end
        else
        begin
            status = h264idr_pkg::STATUS_IDR_SPS;
        end
    end

    h264idr_outbuf u_outbuf (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (accept && s_tlast),
        .push_status (status),
        .space       (space),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

`ifndef SYNTHESIS
    // A new result shows only after a last byte was taken
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("result without a last byte");
`endif

endmodule

`default_nettype wire
